>>> src/sha1_message_digest_assert.svh
// assertion macros for the sha-1 digest block
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// property that must hold on every clock edge out of reset
`define SHA1_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types and constants of the sha-1 digest block
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam int QDEPTH = 2;

  // one classified item between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } item_t;

  // status from the front end to the back end
  typedef struct packed {
    logic q_full;
    logic q_empty;
  } qstat_t;

endpackage

>>> src/sha1_front.sv
// ----------------------------------------------------------------------------
// sha1_front
// input stage and short item queue feeding the compression engine
// ----------------------------------------------------------------------------
module sha1_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [7:0]          in_data_byte,
  input  logic                in_byte_present,
  input  logic                in_end_of_message,
  output logic                full,
  output sha1_pkg::item_t     q_item,
  output sha1_pkg::qstat_t    q_stat,
  input  logic                q_pop
);

  sha1_pkg::item_t mem_r [sha1_pkg::QDEPTH];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wr, rd;

  assign full = (cnt_r == 2'(sha1_pkg::QDEPTH));
  assign wr   = push && !full;
  assign rd   = q_pop && (cnt_r != 2'd0);
  assign q_item = mem_r[rp_r];
  assign q_stat.q_full  = full;
  assign q_stat.q_empty = (cnt_r == 2'd0);

  always_comb begin
    cnt_nxt = cnt_r + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= '{data: in_data_byte, present: in_byte_present,
                       last: in_end_of_message};
    end
  end

endmodule

>>> src/sha1_back.sv
// ----------------------------------------------------------------------------
// sha1_back
// block packing, padding, 80-round compression and digest output
// ----------------------------------------------------------------------------
module sha1_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1_pkg::item_t     q_item,
  input  sha1_pkg::qstat_t    q_stat,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_last_word
);

  typedef enum logic [5:0] {
    S_TAKE = 6'b000001,
    S_PAD  = 6'b000010,
    S_LEN  = 6'b000100,
    S_RND  = 6'b001000,
    S_ADD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t       st_r;
  logic [31:0]  w_r [16];
  logic [31:0]  h_r [5];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [60:0]  cnt_r;
  logic [5:0]   pos_r;
  logic [6:0]   rnd_r;
  logic         fin_r;      // pad byte written, the rest of the padding is zero
  logic         eom_r;      // message end seen, padding still to follow
  logic         lenblk_r;   // current compression carries the length
  logic [2:0]   oidx_r;

  logic [31:0]  wi, f, k, t, bw;
  logic [3:0]   ri;
  logic [7:0]   pbyte;
  logic [3:0]   wsel;
  logic [4:0]   sh;
  logic         wr_byte;

  assign ri = rnd_r[3:0];

  always_comb begin
    bw = w_r[4'(ri + 4'd13)] ^ w_r[4'(ri + 4'd8)] ^ w_r[4'(ri + 4'd2)] ^ w_r[ri];
    wi = (rnd_r < 7'd16) ? w_r[ri] : {bw[30:0], bw[31]};
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = sha1_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = sha1_pkg::K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K3;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + wi;
  end

  // byte placement for take and pad states
  always_comb begin
    wr_byte = 1'b0;
    pbyte = 8'd0;
    if (st_r == S_TAKE && !q_stat.q_empty && q_item.present) begin
      wr_byte = 1'b1;
      pbyte = q_item.data;
    end else if (st_r == S_PAD) begin
      wr_byte = 1'b1;
      pbyte = fin_r ? 8'd0 : sha1_pkg::PAD_BYTE;
    end
    wsel = pos_r[5:2];
    sh = {~pos_r[1:0], 3'b000};
  end

  assign q_pop = (st_r == S_TAKE) && !q_stat.q_empty;
  assign empty = (st_r != S_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 3'd4);

  always_ff @(posedge clk) begin
    if (wr_byte) begin
      if (pos_r[1:0] == 2'd0) w_r[wsel] <= 32'(pbyte) << sh;
      else w_r[wsel] <= w_r[wsel] | (32'(pbyte) << sh);
    end else if (st_r == S_LEN) begin
      w_r[14] <= cnt_r[60:29];
      w_r[15] <= {cnt_r[28:0], 3'b000};
    end else if (st_r == S_RND && rnd_r >= 7'd16) begin
      w_r[ri] <= wi;
    end
    if (st_r == S_RND) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end else begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_TAKE;
      h_r <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3, sha1_pkg::H4};
      cnt_r <= '0;
      pos_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      eom_r <= 1'b0;
      lenblk_r <= 1'b0;
      oidx_r <= '0;
    end else begin
      unique case (st_r)
        S_TAKE: begin
          if (!q_stat.q_empty) begin
            if (q_item.present) begin
              cnt_r <= cnt_r + 61'd1;
              pos_r <= pos_r + 6'd1;
            end
            fin_r <= 1'b0;
            eom_r <= q_item.last;
            if (q_item.present && pos_r == 6'd63) begin
              rnd_r <= '0;
              st_r <= S_RND;
            end else if (q_item.last) begin
              st_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // first pass writes 0x80, then zeros up to the length field
          fin_r <= 1'b1;
          pos_r <= pos_r + 6'd1;
          if (pos_r == 6'd55) begin
            st_r <= S_LEN;
          end else if (pos_r == 6'd63) begin
            // no room for the length: compress and pad a fresh block
            rnd_r <= '0;
            st_r <= S_RND;
          end
        end
        S_LEN: begin
          pos_r <= '0;
          rnd_r <= '0;
          lenblk_r <= 1'b1;
          st_r <= S_RND;
        end
        S_RND: begin
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd79) st_r <= S_ADD;
        end
        S_ADD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          if (lenblk_r) begin
            oidx_r <= '0;
            st_r <= S_OUT;
          end else if (eom_r) begin
            st_r <= S_PAD;
          end else begin
            st_r <= S_TAKE;
          end
        end
        S_OUT: begin
          if (pop) begin
            if (oidx_r == 3'd4) begin
              st_r <= S_TAKE;
              h_r <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3,
                       sha1_pkg::H4};
              cnt_r <= '0;
              pos_r <= '0;
              eom_r <= 1'b0;
              lenblk_r <= 1'b0;
              fin_r <= 1'b0;
              oidx_r <= '0;
            end else begin
              oidx_r <= oidx_r + 3'd1;
            end
          end
        end
        default: st_r <= S_TAKE;
      endcase
    end
  end

endmodule

>>> src/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// sha-1 digest of a byte stream, five digest words per message
// ----------------------------------------------------------------------------
// input: push a beat while full is low; each beat may carry one message byte
//   (in_byte_present) and may close the message (in_end_of_message)
// output: while empty is low a digest word waits on out_*; pop takes it.
//   five beats per message, h0 first, out_last_word on h4
// a two-entry queue sits between the input stage and the compression engine;
//   an accepted beat is registered there and waits while the engine is busy
// bytes are absorbed one per cycle while the engine takes input; every 64th byte
//   adds 80 rounds at one round per cycle and then an add step
// closing a message runs the padding steps and a length step,
//   one or two compressions, then the five output beats
// while the receiver stalls the digest holds and the queue fills, then full
// synchronous reset loads the initial chaining values and clears counts
// ----------------------------------------------------------------------------
`include "sha1_message_digest_assert.svh"

module sha1_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha1_pkg::item_t  q_item;
  sha1_pkg::qstat_t q_stat;
  logic             q_pop;

  sha1_front u_front (
    .clk, .rst_n, .push, .in_data_byte, .in_byte_present, .in_end_of_message,
    .full, .q_item, .q_stat, .q_pop
  );

  sha1_back u_back (
    .clk, .rst_n, .q_item, .q_stat, .q_pop, .empty, .pop,
    .out_digest_word, .out_word_index, .out_last_word
  );

  `SHA1_ASSERT(a_idx_range, empty || out_word_index <= 3'd4, "word index out of range")
  `SHA1_ASSERT(a_last_idx, empty || (out_last_word == (out_word_index == 3'd4)),
    "last word flag mismatch")
  `SHA1_ASSERT(a_pop_nonempty, !(q_pop && q_stat.q_empty), "queue read while empty")
  `SHA1_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_digest_word), "word moved")

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sha-1 digest block: a directed table of short
// messages then random messages, digests predicted in the bench and compared
// word by word, with random gaps on both sides and a long output stall
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eom;
    logic       has_exp;
    logic [31:0] exp_h0;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [7:0] in_data_byte = '0;
  logic in_byte_present = 1'b0;
  logic in_end_of_message = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0] out_word_index;
  logic out_last_word;

  digest_beat_t digest_q[$];
  int errors = 0;
  bit hold_pop = 1'b0;
  int pop_gap = 0;

  // predictor state
  logic [31:0] chain[5];
  logic [31:0] blk[16];
  logic [60:0] byte_cnt;

  always #5 clk = ~clk;

  sha1_message_digest i_dut (
    .clk, .rst_n, .push, .full, .in_data_byte, .in_byte_present,
    .in_end_of_message, .empty, .pop, .out_digest_word, .out_word_index,
    .out_last_word
  );

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic clear_chain();
    chain[0] = sha1_pkg::H0; chain[1] = sha1_pkg::H1; chain[2] = sha1_pkg::H2;
    chain[3] = sha1_pkg::H3; chain[4] = sha1_pkg::H4;
    byte_cnt = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, wi, t;
    w = blk;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 16) wi = w[i];
      else begin
        wi = rol(w[(i + 13) & 15] ^ w[(i + 8) & 15] ^ w[(i + 2) & 15] ^ w[i & 15], 1);
        w[i & 15] = wi;
      end
      if (i < 20) begin f = (b & c) | (~b & d); k = sha1_pkg::K0; end
      else if (i < 40) begin f = b ^ c ^ d; k = sha1_pkg::K1; end
      else if (i < 60) begin f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2; end
      else begin f = b ^ c ^ d; k = sha1_pkg::K3; end
      t = rol(a, 5) + f + e + k + wi;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic place_byte(int pos, logic [7:0] v);
    if ((pos & 3) == 0) blk[pos >> 2] = '0;
    blk[pos >> 2] |= 32'(v) << (24 - 8 * (pos & 3));
  endtask

  // advance the predicted digest by one accepted beat
  task automatic digest_absorb(logic [7:0] data, logic present, logic eom);
    int pos;
    logic [63:0] bits;
    digest_beat_t r;
    if (present) begin
      pos = int'(byte_cnt[5:0]);
      place_byte(pos, data);
      byte_cnt++;
      if (pos == 63) compress_block();
    end
    if (!eom) return;
    bits = {byte_cnt, 3'b000};
    pos = int'(byte_cnt[5:0]);
    place_byte(pos, sha1_pkg::PAD_BYTE);
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin place_byte(pos, 8'h00); pos++; end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin place_byte(pos, 8'h00); pos++; end
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    compress_block();
    for (int j = 0; j < 5; j++) begin
      r.word = chain[j]; r.idx = 3'(j); r.last = (j == 4);
      digest_q = {digest_q, r};
    end
    clear_chain();
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_beat(logic [7:0] d, logic p, logic e);
    push <= 1'b1;
    in_data_byte <= d;
    in_byte_present <= p;
    in_end_of_message <= e;
    do @(posedge clk); while (full);
    digest_absorb(d, p, e);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_message(int len, bit gaps);
    for (int i = 0; i < len; i++) begin
      send_beat(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1));
      if (gaps) idle_gap();
    end
    if (len == 0 || !in_end_of_message) send_beat(8'($urandom), 1'b0, 1'b1);
    if (gaps) idle_gap();
  endtask

  // output side: check every popped beat, random stalls
  always @(posedge clk) begin
    digest_beat_t w;
    if (rst_n && pop && !empty) begin
      if (digest_q.size() == 0) begin
        report("unexpected beat", out_digest_word, 32'h0);
      end else begin
        w = digest_q.pop_front();
        if (out_digest_word !== w.word) report("digest_word", out_digest_word, w.word);
        if (out_word_index !== w.idx) report("word_index", 32'(out_word_index), 32'(w.idx));
        if (out_last_word !== w.last) report("last_word", 32'(out_last_word), 32'(w.last));
      end
    end
    if (hold_pop) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      pop_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    stim_row_t rows[10];
    stim_row_t r;
    int n;
    clear_chain();
    for (int i = 0; i < 16; i++) blk[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, "abc" with end on the last byte, extremes 00/ff, end alone
    rows = '{
      '{8'hff, 1'b0, 1'b1, 1'b1, 32'hda39a3ee},
      '{8'h61, 1'b1, 1'b0, 1'b0, '0},
      '{8'h62, 1'b1, 1'b0, 1'b0, '0},
      '{8'h63, 1'b1, 1'b1, 1'b1, 32'ha9993e36},
      '{8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{8'hff, 1'b1, 1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, 1'b0, '0},
      '{8'haa, 1'b1, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{8'hff, 1'b1, 1'b1, 1'b0, '0}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_beat(r.data, r.present, r.eom);
      // first word of a fresh digest sits five from the back
      if (r.has_exp) digest_q[digest_q.size() - 5].word = r.exp_h0;
    end
    push <= 1'b0;
    wait (digest_q.size() == 0);
    @(posedge clk);

    // 56 bytes: no room for the length, padding runs into a second block
    send_message(56, 1'b0);

    // long output stall so the queue fills and full stalls the sender
    hold_pop = 1'b1;
    fork
      begin repeat (400) @(posedge clk); hold_pop = 1'b0; end
      begin send_message(3, 1'b0); send_message(0, 1'b0); send_message(2, 1'b0); end
    join

    // pause until all digests drained
    push <= 1'b0;
    wait (digest_q.size() == 0);
    @(posedge clk);

    // random messages, mostly short, now and then near a block boundary
    n = 0;
    while (n < 40) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 64) : $urandom_range(0, 12);
      send_message(len, 1'b1);
      n += len + 1;
    end
    push <= 1'b0;
    wait (digest_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
